@@ hw/rtl/asid_generation_allocator_assert.svh @@
// Assertion macros used by the allocator's checker.
`ifndef ASID_GENERATION_ALLOCATOR_ASSERT_SVH
`define ASID_GENERATION_ALLOCATOR_ASSERT_SVH

// Implication checked on the same edge.
`define AGA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Implication checked on the following edge.
`define AGA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

@@ hw/rtl/aga_pkg.sv @@
`default_nettype none
package aga_pkg;

    localparam int ID_BITS_DEF   = 16;
    localparam int CPU_COUNT_DEF = 4;
    localparam int CTX_W         = 64;
    localparam int CPU_W         = 2;
    localparam int HW_ASID_W     = 16;
    localparam int S_TDATA_W     = 72;
    localparam int M_TDATA_W     = 88;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_SWAP,
        S_MAPRD,
        S_MAPCK,
        S_SRD,
        S_SCK,
        S_REB,
        S_FINN
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLR,
        OP_FIN_IGN,
        OP_FIN_FAST,
        OP_FIN_SAME,
        OP_FIN_NEW,
        OP_SWAP_START,
        OP_SWAP,
        OP_MAP_RD,
        OP_MAP_SET,
        OP_SRCH_INIT,
        OP_SRD,
        OP_SNEXT,
        OP_SHIT,
        OP_ROLL,
        OP_REB,
        OP_FULL
    } dp_op_t;

    typedef struct packed {
        logic cpu_ok;
        logic fast;
        logic same_gen;
        logic id_zero;
        logic idx_last;
        logic swap_hit;
        logic map_bit;
        logic scan_end;
        logic clr_last;
        logic rolling;
        logic after_roll;
        logic out_busy;
    } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/asid_generation_allocator.sv @@
// Flow: a reuse or same-generation hit, or an out-of-range cpu, is answered from the evaluation
//   state; a nonzero stale id goes through the reserved-id swap over every cpu and, unless it is
//   reserved, the map probe; a zero id or a taken ASID goes to the search, then to the finish.
// Rollover: the generation steps, the ASID map is cleared, then the reserved ids of every cpu
//   are rebuilt. Throughput: one request in flight; the next transfer waits for the result.
// Reset: asynchronous, active low; afterwards the map is cleared before a request is taken.
`default_nettype none
module asid_generation_allocator
    import aga_pkg::*;
#(
    parameter int ID_BITS   = ID_BITS_DEF,
    parameter int CPU_COUNT = CPU_COUNT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // cpu_index[2], context_id[64], pad
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata    // new_context_id[64], hw_asid[16],
                                                  // flush_tlb_all, id_changed, pad
);

    dp_op_t                 op;
    status_t                status;
    logic [CTX_W-1:0]       new_context_id;
    logic [HW_ASID_W-1:0]   hw_asid;
    logic                   flush_tlb_all;
    logic                   id_changed;

    aga_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    aga_datapath #(
        .ID_BITS   (ID_BITS),
        .CPU_COUNT (CPU_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .cpu_index      (s_tdata[CPU_W-1:0]),
        .context_id     (s_tdata[CPU_W+CTX_W-1:CPU_W]),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .new_context_id (new_context_id),
        .hw_asid        (hw_asid),
        .flush_tlb_all  (flush_tlb_all),
        .id_changed     (id_changed),
        .status         (status)
    );

    assign m_tdata = {6'b0, id_changed, flush_tlb_all, hw_asid, new_context_id};

endmodule
`default_nettype wire

@@ hw/rtl/aga_controller.sv @@
`default_nettype none
module aga_controller
    import aga_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output dp_op_t       op
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE) && !status.out_busy;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = status.rolling ? S_REB : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!status.cpu_ok || status.fast || status.same_gen)
                begin
                    state_next = S_IDLE;
                end
                else if (status.id_zero)
                begin
                    state_next = S_SRD;
                end
                else
                begin
                    state_next = S_SWAP;
                end
            end
            S_SWAP:
            begin
                if (status.idx_last)
                begin
                    state_next = status.swap_hit ? S_FINN : S_MAPRD;
                end
            end
            S_MAPRD: state_next = S_MAPCK;
            S_MAPCK: state_next = status.map_bit ? S_SRD : S_FINN;
            S_SRD:
            begin
                if (!status.scan_end)
                begin
                    state_next = S_SCK;
                end
                else
                begin
                    state_next = status.after_roll ? S_FINN : S_CLEAR;
                end
            end
            S_SCK:   state_next = status.map_bit ? S_SRD : S_FINN;
            S_REB:
            begin
                if (status.idx_last)
                begin
                    state_next = S_SRD;
                end
            end
            S_FINN:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op = OP_NONE;
        case (state_reg)
            S_CLEAR: op = OP_CLR;
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    op = OP_LOAD;
                end
            end
            S_EVAL:
            begin
                if (!status.cpu_ok)
                begin
                    op = OP_FIN_IGN;
                end
                else if (status.fast)
                begin
                    op = OP_FIN_FAST;
                end
                else if (status.same_gen)
                begin
                    op = OP_FIN_SAME;
                end
                else if (status.id_zero)
                begin
                    op = OP_SRCH_INIT;
                end
                else
                begin
                    op = OP_SWAP_START;
                end
            end
            S_SWAP:  op = OP_SWAP;
            S_MAPRD: op = OP_MAP_RD;
            S_MAPCK: op = status.map_bit ? OP_SRCH_INIT : OP_MAP_SET;
            S_SRD:
            begin
                if (!status.scan_end)
                begin
                    op = OP_SRD;
                end
                else
                begin
                    op = status.after_roll ? OP_FULL : OP_ROLL;
                end
            end
            S_SCK:   op = status.map_bit ? OP_SNEXT : OP_SHIT;
            S_REB:   op = OP_REB;
            S_FINN:  op = OP_FIN_NEW;
            default: op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/aga_datapath.sv @@
`default_nettype none
module aga_datapath
    import aga_pkg::*;
#(
    parameter int ID_BITS   = ID_BITS_DEF,
    parameter int CPU_COUNT = CPU_COUNT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dp_op_t                op,
    input  wire logic [CPU_W-1:0]      cpu_index,
    input  wire logic [CTX_W-1:0]      context_id,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic [CTX_W-1:0]           new_context_id,
    output logic [HW_ASID_W-1:0]       hw_asid,
    output logic                       flush_tlb_all,
    output logic                       id_changed,
    output status_t                    status
);

    localparam int ASID_COUNT = 1 << ID_BITS;
    localparam int GW         = CTX_W - ID_BITS;
    localparam int IW         = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

    logic                  map_mem [ASID_COUNT];
    logic                  map_q_reg;
    logic                  mem_we;
    logic [ID_BITS-1:0]    mem_waddr;
    logic                  mem_wdata;
    logic [ID_BITS-1:0]    mem_raddr;

    logic [CPU_W-1:0]      cpu_reg, cpu_next;
    logic [CTX_W-1:0]      id_reg, id_next;
    logic [CTX_W-1:0]      res_reg, res_next;
    logic [GW-1:0]         gen_reg, gen_next;
    logic [ID_BITS-1:0]    cursor_reg, cursor_next;
    logic [ID_BITS:0]      scan_reg, scan_next;
    logic [ID_BITS-1:0]    cnt_reg, cnt_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic                  hit_reg, hit_next;
    logic                  roll_reg, roll_next;
    logic                  after_reg, after_next;
    logic [CPU_COUNT-1:0]  flush_reg, flush_next;
    logic [CTX_W-1:0]      active_reg [CPU_COUNT];
    logic [CTX_W-1:0]      active_next [CPU_COUNT];
    logic [CTX_W-1:0]      reserved_reg [CPU_COUNT];
    logic [CTX_W-1:0]      reserved_next [CPU_COUNT];
    logic                  out_valid_reg, out_valid_next;
    logic [CTX_W-1:0]      out_id_reg, out_id_next;
    logic                  out_flush_reg, out_flush_next;
    logic                  out_changed_reg, out_changed_next;

    logic [IW-1:0]         cpu_idx;
    logic [IW-1:0]         act_sel;
    logic [CTX_W-1:0]      act_rd;
    logic [CTX_W-1:0]      keep_id;
    logic [CTX_W-1:0]      reb_id;
    logic                  gen_differs;
    logic                  res_match;
    logic [GW-1:0]         gen_inc;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        map_q_reg <= map_mem[mem_raddr];
    end

    assign cpu_idx     = IW'(cpu_reg);
    assign act_sel     = roll_reg ? idx_reg : cpu_idx;
    assign act_rd      = active_reg[act_sel];
    assign gen_differs = id_reg[CTX_W-1:ID_BITS] != gen_reg;
    assign keep_id     = {gen_reg, id_reg[ID_BITS-1:0]};
    assign res_match   = reserved_reg[idx_reg] == id_reg;
    assign reb_id      = (act_rd == '0) ? reserved_reg[idx_reg] : act_rd;
    assign gen_inc     = gen_reg + GW'(1);

    always_comb
    begin
        status.cpu_ok     = 32'(cpu_reg) < CPU_COUNT;
        status.fast       = (act_rd != '0) && !gen_differs;
        status.same_gen   = !gen_differs;
        status.id_zero    = id_reg == '0;
        status.idx_last   = idx_reg == IW'(CPU_COUNT - 1);
        status.swap_hit   = hit_reg || res_match;
        status.map_bit    = map_q_reg;
        status.scan_end   = scan_reg[ID_BITS];
        status.clr_last   = cnt_reg == '1;
        status.rolling    = roll_reg;
        status.after_roll = after_reg;
        status.out_busy   = out_valid_reg && !m_tready;
    end

    always_comb
    begin
        cpu_next         = cpu_reg;
        id_next          = id_reg;
        res_next         = res_reg;
        gen_next         = gen_reg;
        cursor_next      = cursor_reg;
        scan_next        = scan_reg;
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        hit_next         = hit_reg;
        roll_next        = roll_reg;
        after_next       = after_reg;
        flush_next       = flush_reg;
        active_next      = active_reg;
        reserved_next    = reserved_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_id_next      = out_id_reg;
        out_flush_next   = out_flush_reg;
        out_changed_next = out_changed_reg;
        mem_we           = 1'b0;
        mem_waddr        = id_reg[ID_BITS-1:0];
        mem_wdata        = 1'b1;
        mem_raddr        = scan_reg[ID_BITS-1:0];

        case (op)
            OP_LOAD:
            begin
                cpu_next = cpu_index;
                id_next  = context_id;
            end
            OP_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = 1'b0;
                cnt_next  = cnt_reg + ID_BITS'(1);
            end
            OP_FIN_IGN:
            begin
                out_valid_next   = 1'b1;
                out_id_next      = id_reg;
                out_flush_next   = 1'b0;
                out_changed_next = 1'b0;
            end
            OP_FIN_FAST:
            begin
                active_next[cpu_idx] = id_reg;
                out_valid_next       = 1'b1;
                out_id_next          = id_reg;
                out_flush_next       = 1'b0;
                out_changed_next     = 1'b0;
            end
            OP_FIN_SAME:
            begin
                active_next[cpu_idx] = id_reg;
                flush_next[cpu_idx]  = 1'b0;
                out_valid_next       = 1'b1;
                out_id_next          = id_reg;
                out_flush_next       = flush_reg[cpu_idx];
                out_changed_next     = 1'b0;
            end
            OP_FIN_NEW:
            begin
                active_next[cpu_idx] = res_reg;
                flush_next[cpu_idx]  = 1'b0;
                out_valid_next       = 1'b1;
                out_id_next          = res_reg;
                out_flush_next       = flush_reg[cpu_idx];
                out_changed_next     = 1'b1;
            end
            OP_SWAP_START:
            begin
                idx_next = '0;
                hit_next = 1'b0;
                res_next = keep_id;
            end
            OP_SWAP:
            begin
                if (res_match)
                begin
                    reserved_next[idx_reg] = res_reg;
                    hit_next               = 1'b1;
                end
                if (!status.idx_last)
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            OP_MAP_RD:
            begin
                mem_raddr = id_reg[ID_BITS-1:0];
            end
            OP_MAP_SET:
            begin
                mem_we = 1'b1;
            end
            OP_SRCH_INIT:
            begin
                scan_next  = {1'b0, cursor_reg};
                after_next = 1'b0;
            end
            OP_SRD:
            begin
                mem_raddr = scan_reg[ID_BITS-1:0];
            end
            OP_SNEXT:
            begin
                scan_next = scan_reg + (ID_BITS + 1)'(1);
            end
            OP_SHIT:
            begin
                mem_we      = 1'b1;
                mem_waddr   = scan_reg[ID_BITS-1:0];
                cursor_next = scan_reg[ID_BITS-1:0];
                res_next    = {gen_reg, scan_reg[ID_BITS-1:0]};
            end
            OP_ROLL:
            begin
                gen_next  = (gen_inc == '0) ? GW'(1) : gen_inc;
                roll_next = 1'b1;
                cnt_next  = '0;
                idx_next  = '0;
            end
            OP_REB:
            begin
                mem_we                 = 1'b1;
                mem_waddr              = reb_id[ID_BITS-1:0];
                reserved_next[idx_reg] = reb_id;
                active_next[idx_reg]   = '0;
                flush_next[idx_reg]    = 1'b1;
                if (status.idx_last)
                begin
                    roll_next  = 1'b0;
                    after_next = 1'b1;
                    scan_next  = (ID_BITS + 1)'(1);
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            OP_FULL:
            begin
                cursor_next = '0;
                res_next    = {gen_reg, {ID_BITS{1'b0}}};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg       <= GW'(1);
            cursor_reg    <= ID_BITS'(1);
            scan_reg      <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            roll_reg      <= 1'b0;
            after_reg     <= 1'b0;
            flush_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CPU_COUNT; i++)
            begin
                active_reg[i]   <= '0;
                reserved_reg[i] <= '0;
            end
        end
        else
        begin
            gen_reg       <= gen_next;
            cursor_reg    <= cursor_next;
            scan_reg      <= scan_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            hit_reg       <= hit_next;
            roll_reg      <= roll_next;
            after_reg     <= after_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
            active_reg    <= active_next;
            reserved_reg  <= reserved_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cpu_reg         <= cpu_next;
        id_reg          <= id_next;
        res_reg         <= res_next;
        out_id_reg      <= out_id_next;
        out_flush_reg   <= out_flush_next;
        out_changed_reg <= out_changed_next;
    end

    assign m_tvalid       = out_valid_reg;
    assign new_context_id = out_id_reg;
    assign hw_asid        = HW_ASID_W'(out_id_reg[ID_BITS-1:0]);
    assign flush_tlb_all  = out_flush_reg;
    assign id_changed     = out_changed_reg;

endmodule
`default_nettype wire

@@ hw/rtl/aga_checker.sv @@
`default_nettype none
`include "asid_generation_allocator_assert.svh"
module aga_checker
    import aga_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
)
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [S_TDATA_W-1:0]  s_tdata,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata
);

    `AGA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `AGA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    `AGA_ASSERT_NOW(a_asid_low, m_tvalid, m_tdata[79:64] == 16'(m_tdata[ID_BITS-1:0]))
    `AGA_ASSERT_NOW(a_new_gen, m_tvalid && m_tdata[81], m_tdata[63:ID_BITS] != '0)

endmodule

bind asid_generation_allocator aga_checker #(
    .ID_BITS (ID_BITS)
) u_aga_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

@@ verif/asid_generation_allocator_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module asid_generation_allocator_checker
    import aga_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    output int                        fail_count,
    output int                        outstanding,
    output int                        rollovers
);

    localparam int ASIDS = 1 << ID_BITS_DEF;

    typedef struct packed {
        logic [CTX_W-1:0]     ctx;
        logic [HW_ASID_W-1:0] asid;
        logic                 flush;
        logic                 changed;
    } switch_result_t;

    switch_result_t  expected_q[$];
    bit              asid_used[ASIDS];
    logic [CTX_W-1:0] active_ctx[CPU_COUNT_DEF];
    logic [CTX_W-1:0] reserved_ctx[CPU_COUNT_DEF];
    bit              flush_owed[CPU_COUNT_DEF];
    logic [CTX_W-ID_BITS_DEF-1:0] gen;
    int              cursor;

    function automatic logic [CTX_W-1:0] gen_bits();
        return {gen, {ID_BITS_DEF{1'b0}}};
    endfunction

    function automatic bit stale_gen(logic [CTX_W-1:0] id);
        return (id[CTX_W-1:ID_BITS_DEF] != gen);
    endfunction

    function automatic int first_free(int from);
        for (int k = from; k < ASIDS; k++)
            if (!asid_used[k])
                return k;
        return ASIDS;
    endfunction

    function automatic logic [CTX_W-1:0] allocate_ctx(logic [CTX_W-1:0] id);
        logic [CTX_W-1:0] keep;
        logic [CTX_W-1:0] a;
        bit               hit;
        int               k;
        if (id != 0)
        begin
            keep = gen_bits() | CTX_W'(id[ID_BITS_DEF-1:0]);
            hit  = 0;
            for (int i = 0; i < CPU_COUNT_DEF; i++)
                if (reserved_ctx[i] == id)
                begin
                    reserved_ctx[i] = keep;
                    hit = 1;
                end
            if (hit)
                return keep;
            if (!asid_used[id[ID_BITS_DEF-1:0]])
            begin
                asid_used[id[ID_BITS_DEF-1:0]] = 1;
                return keep;
            end
        end
        k = first_free(cursor);
        if (k == ASIDS)
        begin
            gen = gen + 1'b1;
            if (gen == 0)
                gen = 1;
            rollovers++;
            asid_used = '{default: 0};
            for (int i = 0; i < CPU_COUNT_DEF; i++)
            begin
                a = active_ctx[i];
                active_ctx[i] = 0;
                if (a == 0)
                    a = reserved_ctx[i];
                asid_used[a[ID_BITS_DEF-1:0]] = 1;
                reserved_ctx[i] = a;
                flush_owed[i] = 1;
            end
            k = first_free(1);
            if (k == ASIDS)
            begin
                cursor = 0;
                return gen_bits();
            end
        end
        asid_used[k] = 1;
        cursor = k;
        return gen_bits() | CTX_W'(k);
    endfunction

    function automatic switch_result_t switch_context(logic [CPU_W-1:0] cpu,
                                                      logic [CTX_W-1:0] id);
        switch_result_t r;
        r = '0;
        if (!(active_ctx[cpu] != 0 && !stale_gen(id)))
        begin
            if (stale_gen(id))
            begin
                id = allocate_ctx(id);
                r.changed = 1;
            end
            if (flush_owed[cpu])
            begin
                flush_owed[cpu] = 0;
                r.flush = 1;
            end
        end
        active_ctx[cpu] = id;
        r.ctx  = id;
        r.asid = id[HW_ASID_W-1:0];
        return r;
    endfunction

    assign outstanding = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        switch_result_t exp_r;
        switch_result_t got;
        if (!rst_n)
        begin
            expected_q.delete();
            asid_used    = '{default: 0};
            active_ctx   = '{default: '0};
            reserved_ctx = '{default: '0};
            flush_owed   = '{default: 0};
            gen          = 1;
            cursor       = 1;
            fail_count   = 0;
            rollovers    = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_q.push_back(switch_context(s_tdata[CPU_W-1:0],
                                                    s_tdata[CPU_W+CTX_W-1:CPU_W]));
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[CTX_W-1:0], m_tdata[CTX_W+HW_ASID_W-1:CTX_W],
                       m_tdata[CTX_W+HW_ASID_W], m_tdata[CTX_W+HW_ASID_W+1]};
                if (expected_q.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (got.ctx !== exp_r.ctx)
                    begin
                        $error("new_context_id: expected %h, got %h", exp_r.ctx, got.ctx);
                        fail_count++;
                    end
                    if (got.asid !== exp_r.asid)
                    begin
                        $error("hw_asid: expected %h, got %h", exp_r.asid, got.asid);
                        fail_count++;
                    end
                    if (got.flush !== exp_r.flush)
                    begin
                        $error("flush_tlb_all: expected %b, got %b", exp_r.flush, got.flush);
                        fail_count++;
                    end
                    if (got.changed !== exp_r.changed)
                    begin
                        $error("id_changed: expected %b, got %b", exp_r.changed, got.changed);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ verif/tb_asid_generation_allocator.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_asid_generation_allocator;
    import aga_pkg::*;

    localparam longint CYCLE_LIMIT = 10000000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   fail_count;
    int                   outstanding;
    int                   rollovers;
    bit                   quiet;
    bit                   flush_seen;
    int                   switches_sent;
    longint               cycles;
    logic [CTX_W-1:0]     seen_ids[$];

    asid_generation_allocator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    asid_generation_allocator_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .rollovers   (rollovers)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_asid_generation_allocator: FAIL");
            $finish;
        end
    end

    // keep a pool of recently issued ids to feed back as stored contexts
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (m_tdata[CTX_W+HW_ASID_W])
                flush_seen <= 1'b1;
            seen_ids.push_back(m_tdata[CTX_W-1:0]);
            if (seen_ids.size() > 64)
                void'(seen_ids.pop_front());
        end
    end

    function automatic int draw_wait();
        if (quiet || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = draw_wait();
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_switch(input logic [CPU_W-1:0] cpu, input logic [CTX_W-1:0] id);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({id, cpu});
        do @(posedge clk); while (!s_tready);
        switches_sent++;
    endtask

    function automatic logic [CTX_W-1:0] pick_ctx();
        logic [CTX_W-1:0] id;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6 && seen_ids.size() > 0)
            id = seen_ids[$urandom_range(0, seen_ids.size() - 1)];
        else if (sel < 8)
            id = '0;
        else
            id = {$urandom, $urandom};
        if (sel == 5)
            id[ID_BITS_DEF-1:0] = HW_ASID_W'($urandom);
        return id;
    endfunction

    task automatic random_switches(input int count);
        for (int i = 0; i < count; i++)
            send_switch(CPU_W'($urandom_range(0, CPU_COUNT_DEF - 1)), pick_ctx());
    endtask

    initial
    begin
        int burst;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        quiet         = 1'b0;
        flush_seen    = 1'b0;
        switches_sent = 0;
        cycles        = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // stale active: same generation on an idle cpu
        send_switch(2'd3, 64'h0000_0000_0001_1234);
        for (int c = 0; c < CPU_COUNT_DEF; c++)
            send_switch(CPU_W'(c), '0);
        for (int c = 0; c < CPU_COUNT_DEF; c++)
            send_switch(CPU_W'(c), 64'h0000_0000_0001_0000 | CTX_W'(c + 1));
        send_switch(2'd0, '1);
        send_switch(2'd1, 64'h0000_0000_0000_FFFF);
        send_switch(2'd2, 64'h0000_0000_0000_00FF);
        send_switch(2'd2, 64'h0000_0000_0001_00FF);
        send_switch(2'd3, 64'hFFFF_FFFF_FFFF_0000);
        send_switch(2'd3, 64'h5555_AAAA_5555_AAAA);
        send_switch(2'd1, 64'hAAAA_5555_AAAA_5555);

        random_switches(440);

        // fresh allocations with no random waits, walking the search cursor
        quiet = 1'b1;
        burst = 0;
        while (!flush_seen && burst < 100)
        begin
            send_switch(2'd0, '0);
            burst++;
            if (s_tvalid)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            while (outstanding != 0)
                @(posedge clk);
        end
        quiet = 1'b0;

        // older ids now hit the reserved and keep paths
        random_switches(340);
        s_tvalid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Sent %0d context switches, %0d in the gap-free burst; %0d rollover(s).",
                 switches_sent, burst, rollovers);
        if (fail_count == 0)
            $display("tb_asid_generation_allocator: PASS");
        else
            $display("tb_asid_generation_allocator: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
